FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RTL (included by stmc_engine)
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset
`define ASSERT_CLK_NR(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hw/rtl/stmc_pkg.sv
// ---------------------------------------------------------------------------
// stmc_pkg
// Constants, types and map composition for the segment tree block.
// ---------------------------------------------------------------------------
package stmc_pkg;

    localparam int LEAF_COUNT = 1024;
    localparam int MAP_SIZE   = 8;
    localparam int ENTRY_W    = 3;
    localparam int MAP_W      = 24;
    localparam int NODES      = 2 * LEAF_COUNT;
    localparam int ADDR_W     = $clog2(NODES);
    localparam int NODE_W     = ADDR_W + 1;   // can hold NODES itself

    localparam logic [MAP_W-1:0] IDENTITY_MAP  = 24'd16434824;
    localparam logic [MAP_W-1:0] NEUTRAL_RESET = 24'd16434824;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WUP,
        ST_QLVL,
        ST_QLD,
        ST_QRD,
        ST_QFIN
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [MAP_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // c[k] = b[a[k]]; an entry past the map keeps its own value
    function automatic logic [MAP_W-1:0] map_compose(input logic [MAP_W-1:0] a,
                                                     input logic [MAP_W-1:0] b);
        logic [MAP_W-1:0]   c;
        logic [ENTRY_W-1:0] idx;
        c = '0;
        for (int k = 0; k < MAP_SIZE && (k * ENTRY_W + ENTRY_W) <= MAP_W; k++) begin
            idx = a[k*ENTRY_W +: ENTRY_W];
            if ({1'b0, idx} < (ENTRY_W+1)'(MAP_SIZE)) begin
                c[k*ENTRY_W +: ENTRY_W] = b[idx*ENTRY_W +: ENTRY_W];
            end else begin
                c[k*ENTRY_W +: ENTRY_W] = idx;
            end
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/stmc_ram.sv
// ---------------------------------------------------------------------------
// stmc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module stmc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/stmc_engine.sv
// ---------------------------------------------------------------------------
// stmc_engine
// Sequencer for tree clear, leaf update walk and range query walk.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stmc_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [9:0]                    i_position,
    input  logic [10:0]                   i_range_end,
    input  logic [stmc_pkg::MAP_W-1:0]    i_new_map,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [stmc_pkg::MAP_W-1:0]    o_result,
    input  logic [stmc_pkg::MAP_W-1:0]    i_neutral,
    output stmc_pkg::t_ram_req            o_ram,
    input  logic [stmc_pkg::MAP_W-1:0]    i_rdata
);

    localparam int AW = stmc_pkg::ADDR_W;
    localparam int NW = stmc_pkg::NODE_W;
    localparam int MW = stmc_pkg::MAP_W;
    localparam logic [NW-1:0] LEAVES = NW'(stmc_pkg::LEAF_COUNT);

    stmc_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [AW-1:0] r_idx, n_idx;
    logic [MW-1:0] r_cur, n_cur;
    logic [NW-1:0] r_i, n_i;
    logic [NW-1:0] r_j, n_j;
    logic [MW-1:0] r_resl, n_resl;
    logic [MW-1:0] r_resr, n_resr;
    logic          r_ovalid, n_ovalid;
    logic [MW-1:0] r_out, n_out;

    logic [NW-1:0] pos_ext, end_ext, pos_c, end_c;
    logic [NW-1:0] i_inc;
    logic [AW-1:0] leaf, parent;
    logic [MW-1:0] par_map;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= stmc_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_cur  <= n_cur;
        r_i    <= n_i;
        r_j    <= n_j;
        r_resl <= n_resl;
        r_resr <= n_resr;
        r_out  <= n_out;
    end

    always_comb begin
        pos_ext = NW'(i_position);
        end_ext = NW'(i_range_end);
        pos_c   = (pos_ext > LEAVES) ? LEAVES : pos_ext;
        end_c   = (end_ext > LEAVES) ? LEAVES : end_ext;
        leaf    = AW'(LEAVES + pos_ext);
        parent  = r_idx >> 1;
        // left child on the left of the composition
        par_map = r_idx[0] ? stmc_pkg::map_compose(i_rdata, r_cur)
                           : stmc_pkg::map_compose(r_cur, i_rdata);
        i_inc   = r_i + NW'(1);
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_idx    = r_idx;
        n_cur    = r_cur;
        n_i      = r_i;
        n_j      = r_j;
        n_resl   = r_resl;
        n_resr   = r_resr;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        o_ready  = 1'b0;
        o_ram    = '0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            stmc_pkg::ST_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_clr;
                o_ram.wdata = stmc_pkg::IDENTITY_MAP;
                n_clr       = r_clr + AW'(1);
                if (&r_clr) begin
                    n_state = stmc_pkg::ST_IDLE;
                end
            end
            stmc_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_mode) begin
                        n_i    = LEAVES + pos_c;
                        n_j    = LEAVES + end_c;
                        n_resl = i_neutral;
                        n_resr = i_neutral;
                        n_state = stmc_pkg::ST_QLVL;
                    end else if (pos_ext < LEAVES) begin
                        // store leaf and fetch its sibling in the same cycle
                        o_ram.we    = 1'b1;
                        o_ram.waddr = leaf;
                        o_ram.wdata = i_new_map;
                        o_ram.raddr = leaf ^ AW'(1);
                        n_idx   = leaf;
                        n_cur   = i_new_map;
                        n_state = stmc_pkg::ST_WUP;
                    end
                end
            end
            stmc_pkg::ST_WUP: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = parent;
                o_ram.wdata = par_map;
                if (parent == AW'(1)) begin
                    n_state = stmc_pkg::ST_IDLE;
                end else begin
                    o_ram.raddr = parent ^ AW'(1);
                    n_idx = parent;
                    n_cur = par_map;
                end
            end
            stmc_pkg::ST_QLVL: begin
                if (r_i >= r_j) begin
                    n_state = stmc_pkg::ST_QFIN;
                end else if (r_i[0]) begin
                    o_ram.raddr = AW'(r_i);
                    n_state = stmc_pkg::ST_QLD;
                end else if (r_j[0]) begin
                    o_ram.raddr = AW'(r_j - NW'(1));
                    n_state = stmc_pkg::ST_QRD;
                end else begin
                    n_i = r_i >> 1;
                    n_j = r_j >> 1;
                end
            end
            stmc_pkg::ST_QLD: begin
                n_resl = stmc_pkg::map_compose(r_resl, i_rdata);
                if (r_j[0]) begin
                    o_ram.raddr = AW'(r_j - NW'(1));
                    n_i = i_inc;
                    n_state = stmc_pkg::ST_QRD;
                end else begin
                    n_i = i_inc >> 1;
                    n_j = r_j >> 1;
                    n_state = stmc_pkg::ST_QLVL;
                end
            end
            stmc_pkg::ST_QRD: begin
                n_resr = stmc_pkg::map_compose(i_rdata, r_resr);
                // j is odd here, so (j - 1) >> 1 equals j >> 1
                n_i = r_i >> 1;
                n_j = r_j >> 1;
                n_state = stmc_pkg::ST_QLVL;
            end
            stmc_pkg::ST_QFIN: begin
                if (!r_ovalid || i_ready) begin
                    n_out    = stmc_pkg::map_compose(r_resl, r_resr);
                    n_ovalid = 1'b1;
                    n_state  = stmc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stmc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_out;

    `ASSERT_CLK(a_no_wr_in_query,
        (r_state == stmc_pkg::ST_QLVL || r_state == stmc_pkg::ST_QLD ||
         r_state == stmc_pkg::ST_QRD || r_state == stmc_pkg::ST_QFIN) |-> !o_ram.we,
        "tree written during a query walk")
    `ASSERT_CLK(a_no_rw_collide,
        (o_ram.we && o_ram.waddr == o_ram.raddr) |-> r_state == stmc_pkg::ST_CLEAR,
        "read and write of the same node in one cycle")
    `ASSERT_CLK(a_no_node0_write,
        (o_ram.we && r_state != stmc_pkg::ST_CLEAR) |-> o_ram.waddr != '0,
        "update walk wrote past the root")
    `ASSERT_CLK(a_result_kept,
        (r_ovalid && !i_ready) |=> (r_ovalid && $stable(r_out)),
        "pending result lost or changed")

endmodule

FILE: hw/rtl/segment_tree_map_composition.sv
// ---------------------------------------------------------------------------
// segment_tree_map_composition
// Segment tree over 8-entry index maps: leaf updates and range composition.
// ---------------------------------------------------------------------------
// Channel    Dir  Handshake                  Payload
// s_axis     in   i_s_axis_tvalid/o_..tready tuser: mode; tdata: position,
//                                            range_end, new_map
// m_axis     out  o_m_axis_tvalid/i_..tready tdata: result_map
// cfg        in   i_cfg_wen                  i_cfg_wdata: neutral_map
//
// After reset a clearing pass writes the identity map into all 2048 tree
// nodes, during which tready is low; cfg writes are taken.
// A leaf write does one RAM write per tree level, the sibling read for
// the next level overlapping the write.
// A query walks up to 11 tree levels, limited by the single RAM read
// port and its registered read; no result for writes.
// A held result in the output register stalls only the final query cycle.
// ---------------------------------------------------------------------------
module segment_tree_map_composition (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [9:0] position, [20:10] range_end, [44:21] new_map, [47:45] zero
    input  logic [47:0] i_s_axis_tdata,
    // [0] mode
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [23:0] result_map
    output logic [23:0] o_m_axis_tdata,
    input  logic        i_cfg_wen,
    input  logic [23:0] i_cfg_wdata
);

    logic [stmc_pkg::MAP_W-1:0] r_neutral;
    stmc_pkg::t_ram_req         ram_req;
    logic [stmc_pkg::MAP_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neutral <= stmc_pkg::NEUTRAL_RESET;
        end else if (i_cfg_wen) begin
            r_neutral <= i_cfg_wdata;
        end
    end

    stmc_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_mode      (i_s_axis_tuser),
        .i_position  (i_s_axis_tdata[9:0]),
        .i_range_end (i_s_axis_tdata[20:10]),
        .i_new_map   (i_s_axis_tdata[44:21]),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_result    (o_m_axis_tdata),
        .i_neutral   (r_neutral),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata)
    );

    stmc_ram #(
        .WIDTH (stmc_pkg::MAP_W),
        .DEPTH (stmc_pkg::NODES)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

endmodule
